// ----- design/ouis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouis_pkg
// Shared widths, command and status codes, and the token that travels down
// the cell chain of the ordered unique ID set.
// ----------------------------------------------------------------------------
package ouis_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ID_W    = 32;
  localparam int POS_W   = 6;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 3;
  localparam int TOTAL_W = 7;

  // Command codes (codes 5..7 are ignored)
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE   = 3'd4;

  // Command token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    logic             hit;     // match (or index present) seen so far
    logic [ID_W-1:0]  id_out;  // data picked up by a read
  } tok_t;

endpackage

// ----- design/ordered_unique_id_set_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_id_set_top
// Insertion-ordered set of distinct 32-bit IDs built as a chain of cells.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Beat contents (lowest bit up)
//  --------+--------------------------------+----------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | tdata: id_value[31:0],
//          | in_tuser                       |   position[37:32], zero pad
//          |                                | tuser: command[2:0]
//  out     | out_tvalid/out_tready/out_tdata| tdata: id_out[31:0],
//          | out_tuser                      |   entry_total[38:32], zero pad
//          |                                | tuser: found[0], status[3:1]
//
//  Flow: a command enters cell 0 on acceptance and walks one cell per
//  cycle down the CAPACITY cells; its result is parked in the park
//  register and then shown on out, and the next beat is taken once the
//  result has left the park register. Only one command is in the block
//  at a time.
//  Reset: clears the entry count, the in-flight token and both result
//  slots; stored IDs are not cleared, only slots below the count are used.
//  Stalls: a result waiting in the output slot does not block the next
//  command; one that finishes while that slot is full holds in the park register and blocks it.
// ----------------------------------------------------------------------------
module ordered_unique_id_set_top #(
  parameter int CAPACITY = ouis_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // id_value[31:0], position[37:32], pad
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // id_out[31:0], entry_total[38:32], pad
  output logic [3:0]  out_tuser   // found[0], status[3:1]
);

  localparam int CW = $clog2(CAPACITY+1);

  // Handshake and control state
  logic          in_fire;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Chain wiring: tok[0] feeds cell 0, tok[i+1] leaves cell i
  ouis_pkg::tok_t              tok [CAPACITY+1];
  logic [ouis_pkg::ID_W-1:0]   cell_id [CAPACITY];
  logic [CAPACITY-1:0]         tok_vld;
  ouis_pkg::tok_t              tok_end;

  // Result computed from the token leaving the chain
  logic                        res_found;
  logic [ouis_pkg::ST_W-1:0]   res_status;
  logic [ouis_pkg::ID_W-1:0]   res_id;

  // Park slot and output slot
  logic                        pend_valid_r, pend_valid_nxt;
  logic [39:0]                 pend_data_r;
  logic [3:0]                  pend_user_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [39:0]                 out_data_r;
  logic [3:0]                  out_user_r;
  logic                        out_free;
  logic                        pend_move;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;

  // Inject the command beat straight into cell 0
  always_comb begin
    tok[0].valid  = in_fire;
    tok[0].cmd    = in_tuser[ouis_pkg::CMD_W-1:0];
    tok[0].id     = in_tdata[ouis_pkg::ID_W-1:0];
    tok[0].pos    = in_tdata[ouis_pkg::ID_W +: ouis_pkg::POS_W];
    tok[0].hit    = 1'b0;
    tok[0].id_out = '0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ouis_pkg::ID_W-1:0] nbr;
      if (gi == CAPACITY - 1) begin : g_last
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_id[gi+1];
      end

      ouis_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .count_i  (count_r),
        .tok_i    (tok[gi]),
        .nbr_id_i (nbr),
        .tok_o    (tok[gi+1]),
        .id_o     (cell_id[gi])
      );

      assign tok_vld[gi] = tok[gi+1].valid;
    end
  endgenerate

  assign tok_end = tok[CAPACITY];

  // Settle status and new count once the token has seen every cell
  always_comb begin
    res_found  = 1'b0;
    res_status = ouis_pkg::ST_OK;
    res_id     = '0;
    count_nxt  = count_r;
    if (tok_end.valid) begin
      unique case (tok_end.cmd)
        ouis_pkg::CMD_ADD: begin
          if (tok_end.hit) begin
            res_found  = 1'b1;
            res_status = ouis_pkg::ST_DUP;
          end else if (count_r >= CW'(CAPACITY)) begin
            res_status = ouis_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        ouis_pkg::CMD_REMOVE: begin
          if (tok_end.hit) begin
            res_found = 1'b1;
            count_nxt = count_r - CW'(1);
          end else begin
            res_status = ouis_pkg::ST_MISSING;
          end
        end
        ouis_pkg::CMD_CONTAINS: begin
          if (tok_end.hit) begin
            res_found = 1'b1;
          end else begin
            res_status = ouis_pkg::ST_MISSING;
          end
        end
        ouis_pkg::CMD_READ: begin
          if (tok_end.hit) begin
            res_found = 1'b1;
            res_id    = tok_end.id_out;
          end else begin
            res_status = ouis_pkg::ST_RANGE;
          end
        end
        ouis_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Park slot hands on to the output slot whenever that is free
  assign out_free  = !out_valid_r || out_tready;
  assign pend_move = pend_valid_r && out_free;

  always_comb begin
    pend_valid_nxt = tok_end.valid || (pend_valid_r && !pend_move);
    out_valid_nxt  = pend_move || (out_valid_r && !out_tready);
    busy_nxt       = in_fire || (busy_r && !pend_move);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.valid) begin
      pend_data_r <= {1'b0, ouis_pkg::TOTAL_W'(count_nxt), res_id};
      pend_user_r <= {res_status, res_found};
    end
    if (pend_move) begin
      out_data_r <= pend_data_r;
      out_user_r <= pend_user_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // At most one command walks the chain at a time
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_vld))
    else $error("more than one token in the chain");

  // The count never exceeds the chain length
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // A token or a parked result only exists while a command is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
                   (tok_vld != '0 || pend_valid_r) |-> busy_r)
    else $error("work in flight while not busy");

  // An accepted beat keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> busy_r)
    else $error("busy not raised after accept");

  // The count only moves when a token leaves the chain
  assert property (@(posedge clk) disable iff (!rst_n)
                   !tok_end.valid |=> $stable(count_r))
    else $error("count changed without a finishing command");

endmodule

// ----- design/ouis_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouis_cell
// One slot of the ID chain: holds one ID, inspects the passing command token
// and hands it on, registered, to the next slot.
// ----------------------------------------------------------------------------
module ouis_cell #(
  parameter int CAPACITY = ouis_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(CAPACITY+1)-1:0]      count_i,
  input  ouis_pkg::tok_t                     tok_i,
  input  logic [ouis_pkg::ID_W-1:0]          nbr_id_i,
  output ouis_pkg::tok_t                     tok_o,
  output logic [ouis_pkg::ID_W-1:0]          id_o
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam bit POS_OK = (IDX < (1 << ouis_pkg::POS_W));

  logic [ouis_pkg::ID_W-1:0] id_r, id_nxt;
  ouis_pkg::tok_t            tok_r, tok_nxt;
  logic                      occ;
  logic                      match;
  logic                      pos_hit;

  assign occ   = CW'(IDX) < count_i;
  assign match = occ && (tok_i.id == id_r);

  always_comb begin
    if (POS_OK) begin
      pos_hit = occ && (tok_i.pos == ouis_pkg::POS_W'(IDX));
    end else begin
      pos_hit = 1'b0;
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    id_nxt  = id_r;
    if (tok_i.valid) begin
      unique case (tok_i.cmd)
        ouis_pkg::CMD_ADD: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
          end
          // append at the first free slot unless a duplicate sits upstream
          if ((CW'(IDX) == count_i) && !tok_i.hit) begin
            id_nxt = tok_i.id;
          end
        end
        ouis_pkg::CMD_REMOVE: begin
          if (match || tok_i.hit) begin
            tok_nxt.hit = 1'b1;
            // close the gap: pull the downstream ID one slot up
            if (CW'(IDX + 1) < count_i) begin
              id_nxt = nbr_id_i;
            end
          end
        end
        ouis_pkg::CMD_CONTAINS: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
          end
        end
        ouis_pkg::CMD_READ: begin
          if (pos_hit) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.id_out = id_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign tok_o = tok_r;
  assign id_o  = id_r;

endmodule

// ----- tb/sv/ordered_unique_id_set_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_id_set_top_tb
// Self-checking bench for the insertion-ordered ID set. A queue-based copy
// of the set predicts found, id_out, count and status for every accepted
// command; each result beat is checked against the oldest prediction.
// Directed edge cases run first, then a fill-to-capacity test, then
// random traffic in fill, drain and mixed phases, with idle cycles
// on both sides.
// ----------------------------------------------------------------------------
module ordered_unique_id_set_top_tb;
  import ouis_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
  localparam int POOL_SIZE   = 100;
  localparam int MAX_REPORTS = 40;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_CLEAR + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED } traffic_phase_t;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    id_out;
    logic [TOTAL_W-1:0] total;
    logic [ST_W-1:0]    status;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // id_value[31:0], position[37:32], pad
  logic [2:0]  in_tuser = '0;   // command[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // id_out[31:0], entry_total[38:32], pad
  logic [3:0]  out_tuser;       // found[0], status[3:1]

  // Predicted contents of the set, oldest first
  logic [ID_W-1:0] held_ids[$];
  set_result_t     results_due[$];
  logic [ID_W-1:0] id_pool[POOL_SIZE];

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  ordered_unique_id_set_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Set predictor: apply one command to the local copy, return its result
  // --------------------------------------------------------------------------
  function automatic int find_held(logic [ID_W-1:0] id);
    foreach (held_ids[k]) begin
      if (held_ids[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic set_result_t apply_set_command(logic [CMD_W-1:0] cmd,
                                                    logic [ID_W-1:0] id,
                                                    logic [POS_W-1:0] pos);
    set_result_t r;
    int where;
    r = '0;
    r.status = ST_OK;
    where = find_held(id);
    case (cmd)
      CMD_ADD: begin
        // a duplicate wins over a full store
        if (where >= 0) begin
          r.found = 1'b1;
          r.status = ST_DUP;
        end else if (held_ids.size() >= CAP) begin
          r.status = ST_FULL;
        end else begin
          held_ids.push_back(id);
        end
      end
      CMD_REMOVE: begin
        if (where >= 0) begin
          r.found = 1'b1;
          held_ids.delete(where);   // later entries close the gap
        end else begin
          r.status = ST_MISSING;
        end
      end
      CMD_CONTAINS: begin
        if (where >= 0) r.found = 1'b1;
        else r.status = ST_MISSING;
      end
      CMD_READ: begin
        if (int'(pos) < held_ids.size()) begin
          r.found = 1'b1;
          r.id_out = held_ids[pos];
        end else begin
          r.status = ST_RANGE;
        end
      end
      CMD_CLEAR: held_ids.delete();
      default: ;  // unused codes leave the set alone
    endcase
    r.total = TOTAL_W'(held_ids.size());
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting, capped so a broken build cannot flood the log
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // --------------------------------------------------------------------------
  // Command sender: random idle gap, then hold the beat until taken.
  // tvalid stays high after acceptance so back-to-back beats need only one
  // assignment per edge; drop it with release_input before any pause.
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [ID_W-1:0] id,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {2'b00, pos, id};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    results_due.push_back(apply_set_command(cmd, id, pos));
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    release_input();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    do id = $urandom; while (find_held(id) >= 0);
    return id;
  endfunction

  // Mostly IDs that are held or drawn from a small pool, so hits are common
  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (held_ids.size() > 0 && roll < 45)
      return held_ids[$urandom_range(0, held_ids.size() - 1)];
    if (roll < 85)
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (held_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, held_ids.size() - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Each operation on an empty and a small set, extreme IDs and positions,
  // removal from the front, the unused codes and clear.
  task automatic test_directed_ops();
    send_command(CMD_CONTAINS, 32'h0000_0000, 6'd0);
    send_command(CMD_READ,     32'h0000_0000, 6'd0);
    send_command(CMD_REMOVE,   32'hFFFF_FFFF, 6'd0);
    send_command(CMD_ADD,      32'h0000_0000, 6'd0);
    send_command(CMD_ADD,      32'hFFFF_FFFF, 6'd63);
    send_command(CMD_ADD,      32'h0000_0000, 6'd0);
    send_command(CMD_ADD,      32'h8000_0001, 6'd0);
    send_command(CMD_CONTAINS, 32'hFFFF_FFFF, 6'd0);
    send_command(CMD_READ,     32'h0000_0000, 6'd0);
    send_command(CMD_READ,     32'hFFFF_FFFF, 6'd2);
    send_command(CMD_READ,     32'h0000_0000, 6'd3);
    send_command(CMD_READ,     32'h0000_0000, 6'd63);
    send_command(CMD_REMOVE,   32'h0000_0000, 6'd0);
    send_command(CMD_READ,     32'h0000_0000, 6'd0);
    send_command(CMD_CONTAINS, 32'h0000_0000, 6'd0);
    send_command(CMD_UNUSED_LO,         32'hFFFF_FFFF, 6'd63);
    send_command(CMD_UNUSED_LO + 3'd1,  32'h8000_0001, 6'd1);
    send_command(CMD_UNUSED_HI,         32'hFFFF_FFFF, 6'd63);
    send_command(CMD_REMOVE,   32'h8000_0001, 6'd0);
    send_command(CMD_CLEAR,    32'hFFFF_FFFF, 6'd63);
    send_command(CMD_READ,     32'h0000_0000, 6'd0);
    send_command(CMD_ADD,      32'h5A5A_5A5A, 6'd0);
    send_command(CMD_REMOVE,   32'h5A5A_5A5A, 6'd0);
    send_command(CMD_REMOVE,   32'h5A5A_5A5A, 6'd0);
    wait_drained();
  endtask

  // Fill to capacity, then probe full, duplicate-on-full and the top index
  task automatic test_full_store();
    logic [ID_W-1:0] victim;
    send_command(CMD_CLEAR, $urandom, pick_pos());
    while (held_ids.size() < CAP) send_command(CMD_ADD, fresh_id(), pick_pos());
    send_command(CMD_ADD, fresh_id(), 6'd0);
    send_command(CMD_ADD, held_ids[0], 6'd0);
    send_command(CMD_ADD, held_ids[CAP-1], 6'd0);
    send_command(CMD_READ, $urandom, 6'd63);
    send_command(CMD_READ, $urandom, 6'd0);
    victim = held_ids[CAP/2];
    send_command(CMD_REMOVE, victim, 6'd0);
    send_command(CMD_CONTAINS, victim, 6'd0);
    send_command(CMD_READ, 32'h0, 6'd63);
    send_command(CMD_READ, 32'h0, POS_W'(CAP/2));
    send_command(CMD_ADD, victim, 6'd0);
    send_command(CMD_READ, 32'h0, 6'd63);
    send_command(CMD_REMOVE, held_ids[0], 6'd0);
    send_command(CMD_READ, 32'h0, 6'd0);
    wait_drained();
  endtask

  // Phased random traffic; thresholds steer the count up, down or around
  task automatic test_random_traffic(input traffic_phase_t phase, input int beats);
    int t_add, t_rem, t_has, t_read, t_clear, roll;
    logic [CMD_W-1:0] cmd;
    case (phase)
      PH_FILL:  begin t_add = 60; t_rem = 70; t_has = 80; t_read = 94; t_clear = 95; end
      PH_DRAIN: begin t_add = 10; t_rem = 60; t_has = 75; t_read = 93; t_clear = 94; end
      default:  begin t_add = 35; t_rem = 55; t_has = 70; t_read = 90; t_clear = 93; end
    endcase
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      if (roll < t_add)        cmd = CMD_ADD;
      else if (roll < t_rem)   cmd = CMD_REMOVE;
      else if (roll < t_has)   cmd = CMD_CONTAINS;
      else if (roll < t_read)  cmd = CMD_READ;
      else if (roll < t_clear) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      send_command(cmd, pick_id(), pick_pos());
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, one draw per beat
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare every result beat field by field with the oldest prediction
  always @(posedge clk) begin : result_check
    set_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", out_tdata, 0);
      end else begin
        due = results_due.pop_front();
        if (out_tuser[0] !== due.found)
          report_mismatch("found", out_tuser[0], due.found);
        if (out_tdata[31:0] !== due.id_out)
          report_mismatch("id_out", out_tdata[31:0], due.id_out);
        if (out_tdata[38:32] !== due.total)
          report_mismatch("entry_total", out_tdata[38:32], due.total);
        if (out_tuser[3:1] !== due.status)
          report_mismatch("status", out_tuser[3:1], due.status);
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h0000_0001;
    for (int k = 4; k < POOL_SIZE; k++) id_pool[k] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_full_store();
    test_random_traffic(PH_FILL, 70);
    test_random_traffic(PH_MIXED, 50);
    test_random_traffic(PH_DRAIN, 60);
    test_random_traffic(PH_FILL, 80);
    test_random_traffic(PH_MIXED, 60);
    test_random_traffic(PH_DRAIN, 40);

    // Let any stray result beat surface before closing
    wait_drained();
    repeat (CAP + 8) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results still outstanding", results_due.size(), 0);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
